// ===== design/nlf_pkg.sv =====
// Shared package for the nonlinear ladder filter: parameter defaults, register
// indexes and reset values, the sequencer state type, and the tanh table builder.
// No dependencies.
package nlf_pkg;

  localparam int unsigned NLF_SAMPLE_WIDTH     = 16;
  localparam int unsigned NLF_STAGE_WIDTH      = 24;
  localparam int unsigned NLF_TANH_TABLE_DEPTH = 1024;
  localparam int unsigned STAGE_COUNT          = 4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CUTOFF_GAIN     = 3'd0,
    CFG_RESONANCE       = 3'd1,
    CFG_DRIVE           = 3'd2,
    CFG_FILTER_MODE     = 3'd3,
    CFG_GAIN_CORRECTION = 3'd4
  } cfg_idx_e;

  localparam logic [15:0] CUTOFF_GAIN_RST     = 16'd16384;
  localparam logic [15:0] RESONANCE_RST       = 16'd0;
  localparam logic [15:0] DRIVE_RST           = 16'd0;
  localparam logic [1:0]  FILTER_MODE_RST     = 2'd0;
  localparam logic [15:0] GAIN_CORRECTION_RST = 16'd3901;

  localparam logic [1:0] MODE_LOWPASS  = 2'd0;
  localparam logic [1:0] MODE_BANDPASS = 2'd1;
  localparam logic [1:0] MODE_HIGHPASS = 2'd2;

  typedef struct packed {
    logic [15:0] cutoff_gain;
    logic [15:0] resonance;
    logic [15:0] drive;
    logic [1:0]  filter_mode;
    logic [15:0] gain_correction;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FB_MUL,
    ST_FB_SAT,
    ST_D_SUB,
    ST_DRV_MUL,
    ST_DRV_SAT,
    ST_U,
    ST_TH_MUL,
    ST_TH_IDX,
    ST_TH_LO,
    ST_TH_HI,
    ST_TH_END,
    ST_STG_MUL,
    ST_STG_ADD,
    ST_MODE,
    ST_OUT_MUL,
    ST_OUT_SAT,
    ST_DONE
  } seq_state_e;

  localparam logic [63:0] Q31_ONE = 64'h0000_0000_8000_0000;

  // Restoring long division, used only while building the constant table.
  function automatic logic [63:0] udiv_c(input logic [63:0] num, input logic [63:0] den,
                                         input int nbits);
    logic [64:0] r;
    logic [63:0] q;
    int b;
    r = '0;
    q = '0;
    for (b = nbits - 1; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Entry k holds tanh(4k/depth) in Q.fbits, from a Q31 series for exp.
  function automatic logic [63:0] tanh_entry(input int unsigned k, input int unsigned depth,
                                             input int unsigned fbits);
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] res;
    logic signed [63:0] sum;
    int unsigned n;
    int unsigned sq;
    res = '0;
    if (k != 0) begin
      z = udiv_c(64'(k) << 30, 64'(depth), 44);
      term = Q31_ONE;
      sum = $signed(Q31_ONE);
      for (n = 1; n <= 20; n++) begin
        term = udiv_c((term * z) >> 31, 64'(n), 34);
        if (n[0]) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      e = sum;
      if (e > Q31_ONE) begin
        e = Q31_ONE;
      end
      for (sq = 0; sq < 4; sq++) begin
        e = (e * e) >> 31;
      end
      num = (Q31_ONE - e) << fbits;
      den = Q31_ONE + e;
      res = udiv_c(num + (den >> 1), den, 64);
    end
    return res;
  endfunction

endpackage

// ===== design/nlf_tanh_rom.sv =====
// Constant tanh table with registered read, entries 0 to DEPTH inclusive.
// Depends on nlf_pkg for the table builder function.
module nlf_tanh_rom #(
  parameter int unsigned DEPTH  = nlf_pkg::NLF_TANH_TABLE_DEPTH,
  parameter int unsigned DATA_W = nlf_pkg::NLF_STAGE_WIDTH - 1,
  parameter int unsigned ADDR_W = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic [ADDR_W-1:0] addr_i,
  output logic [DATA_W-1:0] data_o
);
  import nlf_pkg::*;

  logic [DATA_W-1:0] rom_w [DEPTH+1];
  logic [DATA_W-1:0] data_q;

  for (genvar k = 0; k <= DEPTH; k++) begin : g_entry
    localparam logic [DATA_W-1:0] Value = DATA_W'(tanh_entry(k, DEPTH, DATA_W));
    assign rom_w[k] = Value;
  end

  always_ff @(posedge clk_i) begin
    data_q <= rom_w[addr_i];
  end

  assign data_o = data_q;

endmodule

// ===== design/nlf_mul.sv =====
// Shared signed multiplier with a registered product.
// No package dependencies.
module nlf_mul #(
  parameter int unsigned A_W = 33,
  parameter int unsigned B_W = 26
) (
  input  logic                      clk_i,
  input  logic signed [A_W-1:0]     a_i,
  input  logic signed [B_W-1:0]     b_i,
  output logic signed [A_W+B_W-1:0] p_o
);

  logic signed [A_W+B_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== design/nlf_core.sv =====
// Sequencer and datapath of the ladder filter: stage state, working registers,
// tanh evaluation steps and the control of the shared multiplier and table.
// Depends on nlf_pkg.
module nlf_core #(
  parameter int unsigned SAMPLE_WIDTH     = nlf_pkg::NLF_SAMPLE_WIDTH,
  parameter int unsigned STAGE_WIDTH      = nlf_pkg::NLF_STAGE_WIDTH,
  parameter int unsigned TANH_TABLE_DEPTH = nlf_pkg::NLF_TANH_TABLE_DEPTH,
  parameter int unsigned A_W              = STAGE_WIDTH + 9,
  parameter int unsigned B_W              = 26,
  parameter int unsigned ADDR_W           = $clog2(TANH_TABLE_DEPTH + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  nlf_pkg::cfg_t                    cfg_i,
  input  logic                             start_i,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_i,
  output logic                             ready_o,
  input  logic                             out_free_i,
  output logic                             y_valid_o,
  output logic signed [SAMPLE_WIDTH-1:0]   y_o,
  output logic signed [A_W-1:0]            mul_a_o,
  output logic signed [B_W-1:0]            mul_b_o,
  input  logic signed [A_W+B_W-1:0]        mul_p_i,
  output logic [ADDR_W-1:0]                rom_addr_o,
  input  logic [STAGE_WIDTH-2:0]           rom_data_i
);
  import nlf_pkg::*;

  localparam int unsigned F    = STAGE_WIDTH - 1;
  localparam int unsigned W    = F + 9;
  localparam int unsigned PW   = A_W + B_W;
  localparam int unsigned DW   = F;
  localparam int unsigned SF   = SAMPLE_WIDTH - 1;
  localparam int unsigned YW   = W + SAMPLE_WIDTH;
  localparam int unsigned IDXW = PW - F - 2;
  localparam int unsigned SIW  = $clog2(STAGE_COUNT);
  localparam logic signed [W-1:0] TanhLim = {{(W-F-1){1'b0}}, 1'b1, {F{1'b0}}};

  function automatic logic signed [W-1:0] sat_w(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] lo;
    hi = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[W-1:0];
    end else if (v < lo) begin
      return lo[W-1:0];
    end
    return v[W-1:0];
  endfunction

  function automatic logic signed [STAGE_WIDTH-1:0] clamp_s(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] lo;
    hi = {{(PW-STAGE_WIDTH+1){1'b0}}, {(STAGE_WIDTH-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[STAGE_WIDTH-1:0];
    end else if (v < lo) begin
      return lo[STAGE_WIDTH-1:0];
    end
    return v[STAGE_WIDTH-1:0];
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] clamp_y(input logic signed [YW-1:0] v);
    logic signed [YW-1:0] hi;
    logic signed [YW-1:0] lo;
    hi = {{(YW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[SAMPLE_WIDTH-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_WIDTH-1:0];
    end
    return v[SAMPLE_WIDTH-1:0];
  endfunction

  seq_state_e state_q, state_d;
  seq_state_e ret_q, ret_d;
  logic [SIW-1:0] stg_q, stg_d;
  logic signed [STAGE_WIDTH-1:0] stage_q [STAGE_COUNT];
  logic signed [STAGE_WIDTH-1:0] stage_d [STAGE_COUNT];
  logic signed [W-1:0] x_q, x_d;
  logic signed [W-1:0] d_q, d_d;
  logic signed [W-1:0] acc_q, acc_d;
  logic signed [W-1:0] ta_q, ta_d;
  logic neg_q, neg_d;
  logic sat_q, sat_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [F+1:0] frac_q, frac_d;
  logic [DW-1:0] t0_q, t0_d;

  logic signed [W-1:0] x_in;
  logic signed [YW-1:0] y_wide;
  logic [IDXW-1:0] idx_w;
  logic [DW-1:0] diff_w;
  logic [DW-1:0] mag_w;
  logic [18:0] drv_fac;
  logic signed [STAGE_WIDTH-1:0] stage_sel;
  logic signed [W-1:0] diff_ts;
  logic signed [STAGE_WIDTH-1:0] snew;

  if (F >= SF) begin : g_shift_up
    assign x_in   = W'(sample_i) <<< (F - SF);
    assign y_wide = YW'(ta_q) >>> (F - SF);
  end else begin : g_shift_down
    assign x_in   = W'(sample_i >>> (SF - F));
    assign y_wide = YW'(ta_q) <<< (SF - F);
  end

  assign idx_w     = mul_p_i[PW-1:F+2];
  assign diff_w    = (rom_data_i > t0_q) ? (rom_data_i - t0_q) : '0;
  assign mag_w     = sat_q ? t0_q : (t0_q + mul_p_i[F+2 +: DW]);
  assign drv_fac   = 19'd16384 + {1'b0, cfg_i.drive, 2'b00};
  assign stage_sel = stage_q[stg_q];
  assign diff_ts   = ta_q - W'(stage_sel);
  assign snew      = clamp_s(PW'(stage_sel) + (mul_p_i >>> 16));

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    stg_d      = stg_q;
    stage_d    = stage_q;
    x_d        = x_q;
    d_d        = d_q;
    acc_d      = acc_q;
    ta_d       = ta_q;
    neg_d      = neg_q;
    sat_d      = sat_q;
    addr_d     = addr_q;
    frac_d     = frac_q;
    t0_d       = t0_q;
    mul_a_o    = '0;
    mul_b_o    = '0;
    rom_addr_o = addr_q;
    y_valid_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          x_d     = x_in;
          stg_d   = '0;
          state_d = ST_FB_MUL;
        end
      end
      ST_FB_MUL: begin
        mul_a_o = A_W'(stage_q[STAGE_COUNT-1]);
        mul_b_o = B_W'($signed({1'b0, cfg_i.resonance, 2'b00}));
        state_d = ST_FB_SAT;
      end
      ST_FB_SAT: begin
        acc_d   = sat_w(mul_p_i >>> 16);
        state_d = ST_D_SUB;
      end
      ST_D_SUB: begin
        d_d     = sat_w(PW'(x_q) - PW'(acc_q));
        state_d = ST_DRV_MUL;
      end
      ST_DRV_MUL: begin
        mul_a_o = A_W'(d_q);
        mul_b_o = B_W'($signed({1'b0, drv_fac}));
        state_d = ST_DRV_SAT;
      end
      ST_DRV_SAT: begin
        ta_d    = sat_w(mul_p_i >>> 14);
        ret_d   = ST_U;
        state_d = ST_TH_MUL;
      end
      ST_U: begin
        ret_d   = ST_STG_MUL;
        state_d = ST_TH_MUL;
      end
      ST_TH_MUL: begin
        neg_d   = ta_q[W-1];
        mul_a_o = ta_q[W-1] ? -A_W'(ta_q) : A_W'(ta_q);
        mul_b_o = B_W'(TANH_TABLE_DEPTH);
        state_d = ST_TH_IDX;
      end
      ST_TH_IDX: begin
        sat_d      = (idx_w >= IDXW'(TANH_TABLE_DEPTH));
        addr_d     = sat_d ? ADDR_W'(TANH_TABLE_DEPTH) : idx_w[ADDR_W-1:0];
        rom_addr_o = addr_d;
        frac_d     = mul_p_i[F+1:0];
        state_d    = ST_TH_LO;
      end
      ST_TH_LO: begin
        t0_d       = rom_data_i;
        rom_addr_o = sat_q ? addr_q : (addr_q + ADDR_W'(1));
        state_d    = ST_TH_HI;
      end
      ST_TH_HI: begin
        mul_a_o = A_W'($signed({1'b0, diff_w}));
        mul_b_o = B_W'($signed({1'b0, frac_q}));
        state_d = ST_TH_END;
      end
      ST_TH_END: begin
        ta_d    = neg_q ? -W'($signed({1'b0, mag_w})) : W'($signed({1'b0, mag_w}));
        state_d = ret_q;
      end
      ST_STG_MUL: begin
        mul_a_o = A_W'(diff_ts);
        mul_b_o = B_W'($signed({1'b0, cfg_i.cutoff_gain}));
        state_d = ST_STG_ADD;
      end
      ST_STG_ADD: begin
        stage_d[stg_q] = snew;
        ta_d           = W'(snew);
        if (stg_q != SIW'(STAGE_COUNT - 1)) begin
          stg_d   = stg_q + SIW'(1);
          ret_d   = ST_STG_MUL;
          state_d = ST_TH_MUL;
        end else if (cfg_i.filter_mode == MODE_HIGHPASS) begin
          ta_d    = d_q;
          ret_d   = ST_MODE;
          state_d = ST_TH_MUL;
        end else begin
          state_d = ST_MODE;
        end
      end
      ST_MODE: begin
        case (cfg_i.filter_mode)
          MODE_BANDPASS: acc_d = (W'(stage_q[1]) - W'(stage_q[STAGE_COUNT-1])) <<< 1;
          MODE_HIGHPASS: acc_d = ta_q - W'(stage_q[STAGE_COUNT-1]);
          default:       acc_d = W'(stage_q[STAGE_COUNT-1]);
        endcase
        state_d = ST_OUT_MUL;
      end
      ST_OUT_MUL: begin
        mul_a_o = A_W'(acc_q);
        mul_b_o = B_W'($signed({1'b0, cfg_i.gain_correction}));
        state_d = ST_OUT_SAT;
      end
      ST_OUT_SAT: begin
        ta_d    = sat_w(mul_p_i >>> 12);
        ret_d   = ST_DONE;
        state_d = ST_TH_MUL;
      end
      ST_DONE: begin
        if (out_free_i) begin
          y_valid_o = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      stg_q   <= '0;
      for (int i = 0; i < STAGE_COUNT; i++) begin
        stage_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      stg_q   <= stg_d;
      stage_q <= stage_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    d_q    <= d_d;
    acc_q  <= acc_d;
    ta_q   <= ta_d;
    neg_q  <= neg_d;
    sat_q  <= sat_d;
    addr_q <= addr_d;
    frac_q <= frac_d;
    t0_q   <= t0_d;
  end

  assign ready_o = (state_q == ST_IDLE);
  assign y_o     = clamp_y(y_wide);

  a_start_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> state_q == ST_FB_MUL)
    else $error("Accepted sample did not start the feedback step.");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    y_valid_o |=> state_q == ST_IDLE)
    else $error("Sequencer did not return to idle after a result.");

  a_tanh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_TH_END |=> (ta_q < TanhLim) && (ta_q > -TanhLim))
    else $error("Tanh result outside the open unit range.");

  a_sat_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TH_LO && sat_q) |-> addr_q == ADDR_W'(TANH_TABLE_DEPTH))
    else $error("Saturated tanh argument did not select the last table entry.");

endmodule

// ===== design/nonlinear_ladder_filter_top.sv =====
// Top level of the nonlinear four-pole ladder filter: stream ports, configuration
// registers, output register, and the core, multiplier and tanh table instances.
// Depends on nlf_pkg, nlf_tanh_rom, nlf_mul and nlf_core.

// One sample is accepted when the block is idle; the next sample can be taken in
// the cycle after its result has been passed to the output register, so the block
// does not take a new sample before it is through with the last. The pace is set by
// the one registered multiplier that all products share and by the tanh unit, which
// steps through ST_TH_MUL, ST_TH_IDX, ST_TH_LO, ST_TH_HI and ST_TH_END for its two
// reads of the registered table; six tanh evaluations (seven in highpass) make up
// most of the work. A finished result waits in the output register without holding
// up the next sample. No clearing pass is needed after reset.
module nonlinear_ladder_filter_top #(
  parameter int unsigned SAMPLE_WIDTH     = nlf_pkg::NLF_SAMPLE_WIDTH,
  parameter int unsigned STAGE_WIDTH      = nlf_pkg::NLF_STAGE_WIDTH,
  parameter int unsigned TANH_TABLE_DEPTH = nlf_pkg::NLF_TANH_TABLE_DEPTH,
  parameter int unsigned TDATA_W          = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0: sample_in.
  input  logic [TDATA_W-1:0]              s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Fields from bit 0: sample_out.
  output logic [TDATA_W-1:0]              m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [nlf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [nlf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import nlf_pkg::*;

  localparam int unsigned F      = STAGE_WIDTH - 1;
  localparam int unsigned A_W    = F + 10;
  localparam int unsigned B_W    = (F + 3 > 20) ? F + 3 : 20;
  localparam int unsigned ADDR_W = $clog2(TANH_TABLE_DEPTH + 1);

  cfg_t cfg_q;
  logic out_valid_q;
  logic [SAMPLE_WIDTH-1:0] out_data_q;

  logic start;
  logic core_ready;
  logic out_free;
  logic y_valid;
  logic signed [SAMPLE_WIDTH-1:0] y;
  logic signed [A_W-1:0] mul_a;
  logic signed [B_W-1:0] mul_b;
  logic signed [A_W+B_W-1:0] mul_p;
  logic [ADDR_W-1:0] rom_addr;
  logic [F-1:0] rom_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cutoff_gain     <= CUTOFF_GAIN_RST;
      cfg_q.resonance       <= RESONANCE_RST;
      cfg_q.drive           <= DRIVE_RST;
      cfg_q.filter_mode     <= FILTER_MODE_RST;
      cfg_q.gain_correction <= GAIN_CORRECTION_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CUTOFF_GAIN:     cfg_q.cutoff_gain     <= cfg_wdata_i;
        CFG_RESONANCE:       cfg_q.resonance       <= cfg_wdata_i;
        CFG_DRIVE:           cfg_q.drive           <= cfg_wdata_i;
        CFG_FILTER_MODE:     cfg_q.filter_mode     <= cfg_wdata_i[1:0];
        CFG_GAIN_CORRECTION: cfg_q.gain_correction <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = core_ready;
  assign start         = s_axis_tvalid & core_ready;
  assign out_free      = ~out_valid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (y_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (y_valid) begin
      out_data_q <= y;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'(out_data_q);

  nlf_core #(
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .STAGE_WIDTH      (STAGE_WIDTH),
    .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH),
    .A_W              (A_W),
    .B_W              (B_W),
    .ADDR_W           (ADDR_W)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .start_i    (start),
    .sample_i   ($signed(s_axis_tdata[SAMPLE_WIDTH-1:0])),
    .ready_o    (core_ready),
    .out_free_i (out_free),
    .y_valid_o  (y_valid),
    .y_o        (y),
    .mul_a_o    (mul_a),
    .mul_b_o    (mul_b),
    .mul_p_i    (mul_p),
    .rom_addr_o (rom_addr),
    .rom_data_i (rom_data)
  );

  nlf_mul #(
    .A_W (A_W),
    .B_W (B_W)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  nlf_tanh_rom #(
    .DEPTH  (TANH_TABLE_DEPTH),
    .DATA_W (F),
    .ADDR_W (ADDR_W)
  ) u_tanh_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

endmodule

// ===== tb/sv/nonlinear_ladder_filter_top_tb.sv =====
// Self-checking testbench for nonlinear_ladder_filter_top: random and directed samples
// over many register settings, checked against a built-in fixed-point filter predictor.
// Depends on nlf_pkg and the filter RTL.
module nonlinear_ladder_filter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nlf_pkg::*;

  localparam int SAMPLE_W    = NLF_SAMPLE_WIDTH;
  localparam int FRAC        = NLF_STAGE_WIDTH - 1;
  localparam int IN_SHIFT    = FRAC - (SAMPLE_W - 1);
  localparam int TANH_DEPTH  = NLF_TANH_TABLE_DEPTH;
  localparam int TDATA_W     = ((SAMPLE_W + 7) / 8) * 8;
  localparam int PHASE_ITEMS = 90;
  localparam int RAND_PHASES = 17;
  localparam int CYCLE_LIMIT = 1000000;

  localparam logic [1:0]           MODE_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PAST = CFG_IDX_W'(CFG_GAIN_CORRECTION + 1);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX  = {CFG_IDX_W{1'b1}};

  class ladder_scoreboard;
    longint tanh_tab[TANH_DEPTH+1];
    longint stage_val[STAGE_COUNT];
    longint cutoff_gain;
    longint resonance;
    longint drive;
    longint gain_corr;
    logic [1:0] filter_mode;
    logic [SAMPLE_W-1:0] expected_samples[$];
    int errors;

    function new();
      build_tanh_table();
      foreach (stage_val[i]) stage_val[i] = 0;
      cutoff_gain = longint'(CUTOFF_GAIN_RST);
      resonance   = longint'(RESONANCE_RST);
      drive       = longint'(DRIVE_RST);
      filter_mode = FILTER_MODE_RST;
      gain_corr   = longint'(GAIN_CORRECTION_RST);
      errors      = 0;
    endfunction

    function void build_tanh_table();
      bit [63:0] q31;
      bit [63:0] z;
      bit [63:0] term;
      bit [63:0] e;
      bit [63:0] num;
      bit [63:0] den;
      longint sum;
      q31 = 64'd1 << 31;
      tanh_tab[0] = 0;
      for (int k = 1; k <= TANH_DEPTH; k++) begin
        z = (64'(k) << 30) / 64'(TANH_DEPTH);
        term = q31;
        sum = longint'(q31);
        for (int n = 1; n <= 20; n++) begin
          term = ((term * z) >> 31) / 64'(n);
          if (n % 2 == 1) begin
            sum = sum - longint'(term);
          end else begin
            sum = sum + longint'(term);
          end
        end
        if (sum < 0) begin
          sum = 0;
        end
        e = 64'(sum);
        if (e > q31) begin
          e = q31;
        end
        repeat (4) e = (e * e) >> 31;
        num = (q31 - e) << FRAC;
        den = q31 + e;
        tanh_tab[k] = longint'((num + den / 2) / den);
      end
    endfunction

    function longint sat_work(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) << (FRAC + 8)) - 1;
      lo = -(longint'(1) << (FRAC + 8));
      return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function longint clamp_width(longint v, int w);
      longint hi;
      longint lo;
      hi = (longint'(1) << (w - 1)) - 1;
      lo = -(longint'(1) << (w - 1));
      return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function longint tanh_eval(longint arg);
      longint mag;
      longint pos;
      longint idx;
      longint frac;
      longint diff;
      longint r;
      mag  = (arg < 0) ? -arg : arg;
      pos  = mag * TANH_DEPTH;
      idx  = pos >>> (FRAC + 2);
      frac = pos & ((longint'(1) << (FRAC + 2)) - 1);
      if (idx >= TANH_DEPTH) begin
        r = tanh_tab[TANH_DEPTH];
      end else begin
        diff = (tanh_tab[idx+1] > tanh_tab[idx]) ? tanh_tab[idx+1] - tanh_tab[idx] : 0;
        r = tanh_tab[idx] + ((diff * frac) >>> (FRAC + 2));
      end
      return (arg < 0) ? -r : r;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] wdata);
      case (idx)
        CFG_CUTOFF_GAIN:     cutoff_gain = longint'(wdata);
        CFG_RESONANCE:       resonance   = longint'(wdata);
        CFG_DRIVE:           drive       = longint'(wdata);
        CFG_FILTER_MODE:     filter_mode = wdata[1:0];
        CFG_GAIN_CORRECTION: gain_corr   = longint'(wdata);
        default: ;
      endcase
    endfunction

    function logic [SAMPLE_W-1:0] filter_sample(logic [SAMPLE_W-1:0] smp);
      longint x;
      longint fb;
      longint d;
      longint u;
      longint s;
      longint o;
      longint y;
      x  = longint'($signed(smp)) <<< IN_SHIFT;
      fb = sat_work((4 * resonance * stage_val[STAGE_COUNT-1]) >>> 16);
      d  = sat_work(x - fb);
      u  = tanh_eval(sat_work((d * (16384 + 4 * drive)) >>> 14));
      for (int i = 0; i < STAGE_COUNT; i++) begin
        s = stage_val[i];
        s = s + ((cutoff_gain * (tanh_eval(u) - s)) >>> 16);
        s = clamp_width(s, FRAC + 1);
        stage_val[i] = s;
        u = s;
      end
      case (filter_mode)
        MODE_BANDPASS: o = sat_work(2 * (stage_val[1] - stage_val[STAGE_COUNT-1]));
        MODE_HIGHPASS: o = sat_work(tanh_eval(d) - stage_val[STAGE_COUNT-1]);
        default:       o = stage_val[STAGE_COUNT-1];
      endcase
      y = tanh_eval(sat_work((o * gain_corr) >>> 12));
      y = clamp_width(y >>> IN_SHIFT, SAMPLE_W);
      return y[SAMPLE_W-1:0];
    endfunction

    function void note_input(logic [SAMPLE_W-1:0] smp);
      expected_samples.push_back(filter_sample(smp));
    endfunction

    function void check_result(logic [SAMPLE_W-1:0] got);
      logic [SAMPLE_W-1:0] want;
      if (expected_samples.size() == 0) begin
        $error("sample_out transfer with no expected sample: actual %0d", $signed(got));
        errors++;
      end else begin
        want = expected_samples.pop_front();
        if (got !== want) begin
          $error("sample_out mismatch: expected %0d, actual %0d", $signed(want), $signed(got));
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]    m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;

  bit steady = 1'b0;
  int unsigned cycles = 0;
  ladder_scoreboard sb;

  nonlinear_ladder_filter_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 32);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata[SAMPLE_W-1:0]);
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
    while (!steady && $urandom_range(0, 99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'(smp);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(smp);
    @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] wdata);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= wdata;
    @(posedge clk_i);
    sb.write_reg(idx, wdata);
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic [15:0] cg, input logic [15:0] res,
                                input logic [15:0] drv, input logic [15:0] mode_word,
                                input logic [15:0] gc);
    write_cfg(CFG_CUTOFF_GAIN, cg);
    write_cfg(CFG_RESONANCE, res);
    write_cfg(CFG_DRIVE, drv);
    write_cfg(CFG_FILTER_MODE, mode_word);
    write_cfg(CFG_GAIN_CORRECTION, gc);
    write_cfg(CFG_IDX_W'($urandom_range(CFG_IDX_PAST, CFG_IDX_MAX)), 16'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int shape;
    int per;
    logic [15:0] smp;
    logic [15:0] amp;
    sb = new();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    settle();

    // Everything at full scale: deep saturation and the tanh end of table.
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, {14'd0, MODE_BANDPASS}, 16'hFFFF);
    repeat (3) send_sample(16'h7FFF);
    repeat (3) send_sample(16'h8000);
    settle();

    apply_settings(16'h0000, 16'h0000, 16'h0000, {14'd0, MODE_HIGHPASS}, 16'h0000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    settle();

    apply_settings(16'd40000, 16'd50000, 16'd8000, {14'h3FFF, MODE_UNUSED}, 16'd4096);
    send_sample(16'h4000);
    send_sample(16'hC000);
    send_sample(16'h7FFF);
    send_sample(16'h0000);
    send_sample(16'h8001);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      steady = (ph >= 6 && ph < 9);
      apply_settings(pick_word(), pick_word(), pick_word(),
                     (16'($urandom) & 16'hFFFC) | 16'($urandom_range(0, 3)), pick_word());
      shape = $urandom_range(0, 2);
      amp   = 16'($urandom_range(0, 32767));
      per   = $urandom_range(2, 64);
      smp   = 16'($urandom);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (shape == 0 || $urandom_range(0, 9) == 0) begin
          smp = 16'($urandom);
        end else if (shape == 1) begin
          smp = ((i % per) < per / 2) ? amp : -amp;
        end else begin
          smp = smp + 16'($urandom_range(0, 4095)) - 16'd2048;
        end
        send_sample(smp);
      end
    end
    steady = 1'b0;

    settle();
    repeat (60) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/nlf_pkg.sv
design/nlf_tanh_rom.sv
design/nlf_mul.sv
design/nlf_core.sv
design/nonlinear_ladder_filter_top.sv
tb/sv/nonlinear_ladder_filter_top_tb.sv
